@@ hdl/assert_macros.svh @@
// Assertion macros shared by the search block modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed: invariant");

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/stbs_pkg.sv @@
// Shared constants and controller/datapath interface types for the table search.
`timescale 1ns / 1ps

package stbs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int MEM_AW      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = 10;
    localparam int DATA_W      = 32;
    // Range pointers: signed, wide enough for -1 and TABLE_DEPTH
    localparam int PTR_W       = (MEM_AW > IDX_W) ? MEM_AW + 2 : IDX_W + 2;

    // Input beat command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic wr;        // store the input beat's element
        logic load;      // capture key and range of a search beat
        logic rd;        // latch midpoint and read the table there
        logic step;      // compare read data with key, narrow range or mark hit
        logic out_load;  // move the search result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic range_empty;  // low bound above high bound
        logic hit;          // read data equals key
        logic out_free;     // output register can take a result this cycle
    } t_dp_sts;

endpackage

@@ hdl/sorted_table_binary_search.sv @@
// Usage notes:
// Input channel (i_in_valid / o_in_stall): a beat with i_cmd = write stores
// i_element_value at i_element_index (ignored beyond the table) and gives no
// result. A beat with i_cmd = search looks for i_search_key between
// i_low_index and i_high_index inclusive; a high bound beyond the table is
// clamped to the last entry.
// Output channel (o_out_valid / i_out_stall): one beat per search carrying
// o_found and o_match_index (zero when not found).
// Sequencing: a write is stored in the cycle it is accepted. A search runs a
// check state and a compare state per probe, set by the single registered read
// port of the table, then a done state that loads the result once the output
// register is free; a miss ends with a last check that finds the range empty.
// A search makes at most 11 probes for 1024 entries. A new beat is taken after
// a write or a loaded result. o_in_stall is high while a search runs.
// A result waiting under i_out_stall does not block new beats; a second
// result then waits inside the block until the output register frees.
// Reset clears the controller and output valid; the table is not cleared and
// entries must be written before a search probes them.
`timescale 1ns / 1ps

module sorted_table_binary_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_cmd,
    input  logic [stbs_pkg::IDX_W-1:0]         i_element_index,
    input  logic signed [stbs_pkg::DATA_W-1:0] i_element_value,
    input  logic signed [stbs_pkg::DATA_W-1:0] i_search_key,
    input  logic [stbs_pkg::IDX_W-1:0]         i_low_index,
    input  logic [stbs_pkg::IDX_W-1:0]         i_high_index,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_found,
    output logic [stbs_pkg::IDX_W-1:0]         o_match_index
);

    stbs_pkg::t_dp_cmd w_cmd;
    stbs_pkg::t_dp_sts w_sts;

    // Sequencer
    stbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Table, range registers and result register
    stbs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_search_key    (i_search_key),
        .i_low_index     (i_low_index),
        .i_high_index    (i_high_index),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_found         (o_found),
        .o_match_index   (o_match_index)
    );

endmodule

@@ hdl/stbs_datapath.sv @@
// Datapath: table memory, search range registers, compare and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stbs_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  stbs_pkg::t_dp_cmd               i_cmd,
    output stbs_pkg::t_dp_sts               o_sts,
    input  logic [stbs_pkg::IDX_W-1:0]      i_element_index,
    input  logic signed [stbs_pkg::DATA_W-1:0] i_element_value,
    input  logic signed [stbs_pkg::DATA_W-1:0] i_search_key,
    input  logic [stbs_pkg::IDX_W-1:0]      i_low_index,
    input  logic [stbs_pkg::IDX_W-1:0]      i_high_index,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic                            o_found,
    output logic [stbs_pkg::IDX_W-1:0]      o_match_index
);

    localparam logic [stbs_pkg::PTR_W-1:0] DEPTH_P = stbs_pkg::PTR_W'(stbs_pkg::TABLE_DEPTH);
    localparam logic [stbs_pkg::PTR_W-1:0] LAST_P  =
        stbs_pkg::PTR_W'(stbs_pkg::TABLE_DEPTH - 1);
    localparam logic [stbs_pkg::PTR_W-1:0] ONE_P   = stbs_pkg::PTR_W'(1);

    logic signed [stbs_pkg::DATA_W-1:0] r_mem [stbs_pkg::TABLE_DEPTH];
    logic signed [stbs_pkg::DATA_W-1:0] r_rd_data;
    logic signed [stbs_pkg::DATA_W-1:0] r_key;
    logic [stbs_pkg::PTR_W-1:0]         r_lo;
    logic [stbs_pkg::PTR_W-1:0]         r_hi;
    logic [stbs_pkg::PTR_W-1:0]         r_mid;
    logic                               r_hit;
    logic                               r_out_valid;
    logic                               r_found;
    logic [stbs_pkg::IDX_W-1:0]         r_match_index;

    logic [stbs_pkg::PTR_W-1:0]         w_wr_ptr;
    logic [stbs_pkg::PTR_W-1:0]         w_hi_in;
    logic [stbs_pkg::PTR_W:0]           w_sum;
    logic [stbs_pkg::PTR_W-1:0]         w_mid;
    logic                               w_hit;

    // Bound handling of the incoming beat
    assign w_wr_ptr = stbs_pkg::PTR_W'(i_element_index);
    assign w_hi_in  = (stbs_pkg::PTR_W'(i_high_index) >= DEPTH_P) ? LAST_P
                                                                 : stbs_pkg::PTR_W'(i_high_index);

    // Midpoint: both bounds are non-negative whenever a probe is issued
    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[stbs_pkg::PTR_W:1];
    assign w_hit = (r_rd_data == r_key);

    // Status to controller
    assign o_sts.range_empty = ($signed(r_lo) > $signed(r_hi));
    assign o_sts.hit         = w_hit;
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && (w_wr_ptr < DEPTH_P)) begin
            r_mem[w_wr_ptr[stbs_pkg::MEM_AW-1:0]] <= i_element_value;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[w_mid[stbs_pkg::MEM_AW-1:0]];
        end
    end

    // Search range, key and probe position
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_search_key;
            r_lo  <= stbs_pkg::PTR_W'(i_low_index);
            r_hi  <= w_hi_in;
            r_hit <= 1'b0;
        end else if (i_cmd.step) begin
            if (w_hit) begin
                r_hit <= 1'b1;
            end else if (r_rd_data > r_key) begin
                r_hi <= r_mid - ONE_P;
            end else begin
                r_lo <= r_mid + ONE_P;
            end
        end
        if (i_cmd.rd) begin
            r_mid <= w_mid;
        end
    end

    // Output register: holds a beat until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_found       <= r_hit;
            r_match_index <= r_hit ? r_mid[stbs_pkg::IDX_W-1:0] : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_match_index = r_match_index;

    // Checks
    `ASSERT_SAME(a_rd_nonempty, i_clk, i_rst_n, i_cmd.rd, !o_sts.range_empty)
    `ASSERT_SAME(a_load_free, i_clk, i_rst_n, i_cmd.out_load, o_sts.out_free)
    `ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, i_cmd.out_load, o_out_valid)

endmodule

@@ hdl/stbs_ctrl.sv @@
// Controller: input handshake and probe sequencing of the table search.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stbs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_cmd,
    output logic               o_in_stall,
    input  stbs_pkg::t_dp_sts  i_sts,
    output stbs_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == stbs_pkg::CMD_SEARCH) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_CHECK;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.range_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.hit ? S_DONE : S_CHECK;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Checks
    `ASSERT_NEXT(a_hit_done, i_clk, i_rst_n, (r_state == S_CMP) && i_sts.hit, r_state == S_DONE)
    `ASSERT_NEXT(a_empty_done, i_clk, i_rst_n, (r_state == S_CHECK) && i_sts.range_empty,
                 r_state == S_DONE)
    `ASSERT_NEXT(a_rd_cmp, i_clk, i_rst_n, o_cmd.rd, r_state == S_CMP)

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the sorted table binary search block.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 60;
    localparam int MAX_REPORTS    = 10;

    localparam logic signed [stbs_pkg::DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [stbs_pkg::DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    // One input beat, all fields
    typedef struct {
        logic                               cmd;
        logic [stbs_pkg::IDX_W-1:0]         element_index;
        logic signed [stbs_pkg::DATA_W-1:0] element_value;
        logic signed [stbs_pkg::DATA_W-1:0] search_key;
        logic [stbs_pkg::IDX_W-1:0]         low_index;
        logic [stbs_pkg::IDX_W-1:0]         high_index;
    } t_table_beat;

    typedef struct packed {
        logic                       found;
        logic [stbs_pkg::IDX_W-1:0] match_index;
    } t_search_result;

    // Mirror of the table plus the queue of search answers still owed
    class search_scoreboard;
        bit signed [stbs_pkg::DATA_W-1:0] table_mem [stbs_pkg::TABLE_DEPTH];
        bit                               written [stbs_pkg::TABLE_DEPTH];
        t_search_result                   answers_q [$];
        int                               errors;

        function new();
            errors = 0;
            foreach (written[i]) begin
                written[i]   = 1'b0;
                table_mem[i] = '0;
            end
        endfunction

        // Iterative search over the mirror; safe drops if an unwritten entry is probed
        function void probe(input logic signed [stbs_pkg::DATA_W-1:0] key, input int lo,
                            input int hi, output t_search_result res, output bit safe);
            int mid;
            res  = '0;
            safe = 1'b1;
            if (hi > stbs_pkg::TABLE_DEPTH - 1)
                hi = stbs_pkg::TABLE_DEPTH - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (!written[mid])
                    safe = 1'b0;
                if (table_mem[mid] == key) begin
                    res.found       = 1'b1;
                    res.match_index = mid[stbs_pkg::IDX_W-1:0];
                    return;
                end
                if (table_mem[mid] > key)
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        endfunction

        function void log_error(input string msg);
            if (errors < MAX_REPORTS)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endfunction

        // Accepted input beat: update the table or queue the search answer
        function void note_input(input t_table_beat b);
            t_search_result res;
            bit             safe;
            if (b.cmd == stbs_pkg::CMD_WRITE) begin
                if (int'(b.element_index) < stbs_pkg::TABLE_DEPTH) begin
                    table_mem[b.element_index] = b.element_value;
                    written[b.element_index]   = 1'b1;
                end
            end else begin
                probe(b.search_key, int'(b.low_index), int'(b.high_index), res, safe);
                answers_q.push_back(res);
            end
        endfunction

        // Accepted output beat: compare with the oldest answer owed
        function void check_result(input logic found,
                                   input logic [stbs_pkg::IDX_W-1:0] match_index);
            t_search_result exp_res;
            if (answers_q.size() == 0) begin
                log_error($sformatf("result with none expected: found=%0b index=%0d",
                                    found, match_index));
                return;
            end
            exp_res = answers_q.pop_front();
            if (found !== exp_res.found)
                log_error($sformatf("found: expected %0b, got %0b",
                                    exp_res.found, found));
            if (match_index !== exp_res.match_index)
                log_error($sformatf("match_index: expected %0d, got %0d",
                                    exp_res.match_index, match_index));
        endfunction

        function int pending();
            return answers_q.size();
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic                               i_cmd;
    logic [stbs_pkg::IDX_W-1:0]         i_element_index;
    logic signed [stbs_pkg::DATA_W-1:0] i_element_value;
    logic signed [stbs_pkg::DATA_W-1:0] i_search_key;
    logic [stbs_pkg::IDX_W-1:0]         i_low_index;
    logic [stbs_pkg::IDX_W-1:0]         i_high_index;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic                               o_found;
    logic [stbs_pkg::IDX_W-1:0]         o_match_index;

    search_scoreboard sb;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int beats_sent   = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    sorted_table_binary_search uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_search_key    (i_search_key),
        .i_low_index     (i_low_index),
        .i_high_index    (i_high_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_found         (o_found),
        .o_match_index   (o_match_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Drive one beat, with random idle cycles ahead of it, and hold it until taken
    task automatic send_beat(input t_table_beat b);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= b.cmd;
        i_element_index <= b.element_index;
        i_element_value <= b.element_value;
        i_search_key    <= b.search_key;
        i_low_index     <= b.low_index;
        i_high_index    <= b.high_index;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_input(b);
        beats_sent++;
    endtask

    task automatic write_entry(input int idx, input logic signed [stbs_pkg::DATA_W-1:0] val);
        t_table_beat b;
        b.cmd           = stbs_pkg::CMD_WRITE;
        b.element_index = idx[stbs_pkg::IDX_W-1:0];
        b.element_value = val;
        b.search_key    = $urandom;
        b.low_index     = $urandom;
        b.high_index    = $urandom;
        send_beat(b);
    endtask

    // Search beat; a range that would probe unwritten entries becomes an empty range
    task automatic search_range(input logic signed [stbs_pkg::DATA_W-1:0] key, input int lo,
                                input int hi);
        t_table_beat    b;
        t_search_result res;
        bit             safe;
        // Bounds as the block sees them, cut to the index width
        lo = int'(lo[stbs_pkg::IDX_W-1:0]);
        hi = int'(hi[stbs_pkg::IDX_W-1:0]);
        sb.probe(key, lo, hi, res, safe);
        if (!safe) begin
            if (lo == 0) begin
                lo = 1;
                hi = 0;
            end else begin
                hi = lo - 1;
            end
        end
        b.cmd           = stbs_pkg::CMD_SEARCH;
        b.element_index = $urandom;
        b.element_value = $urandom;
        b.search_key    = key;
        b.low_index     = lo[stbs_pkg::IDX_W-1:0];
        b.high_index    = hi[stbs_pkg::IDX_W-1:0];
        send_beat(b);
    endtask

    // Non-decreasing run of entries, then searches inside it
    task automatic run_segment();
        int                                 start;
        int                                 len;
        int                                 n_search;
        int                                 lo;
        int                                 hi;
        int                                 pick;
        longint                             val;
        longint                             step;
        logic signed [stbs_pkg::DATA_W-1:0] key;
        start = $urandom_range(stbs_pkg::TABLE_DEPTH - 1);
        len   = ($urandom_range(9) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 1);
        if (start + len > stbs_pkg::TABLE_DEPTH)
            len = stbs_pkg::TABLE_DEPTH - start;
        case ($urandom_range(9))
            0:       val = KEY_MIN;
            1:       val = KEY_MAX - $urandom_range(100);
            default: val = $signed($urandom);
        endcase
        for (int i = 0; i < len; i++) begin
            write_entry(start + i, val[stbs_pkg::DATA_W-1:0]);
            step = $urandom_range(1) ? $urandom_range(3) : $urandom_range(32'h03FF_FFFF);
            val  = val + step;
            if (val > KEY_MAX)
                val = KEY_MAX;
        end
        n_search = $urandom_range(6, 1);
        for (int j = 0; j < n_search; j++) begin
            lo = start + $urandom_range(len - 1);
            hi = lo + $urandom_range(start + len - 1 - lo);
            if ($urandom_range(9) == 0)
                lo = hi + 1;
            pick = $urandom_range(hi >= lo ? hi - lo : 0) + (hi >= lo ? lo : hi);
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: key = sb.table_mem[pick];
                6:                key = sb.table_mem[pick] + 1;
                7:                key = sb.table_mem[pick] - 1;
                8:                key = $urandom;
                default:          key = $urandom_range(1) ? KEY_MIN : KEY_MAX;
            endcase
            search_range(key, lo, hi);
        end
    endtask

    // Stray write anywhere (may break the ordering) or a search over a random range
    task automatic run_noise();
        int lo;
        int hi;
        if ($urandom_range(1)) begin
            write_entry($urandom_range(stbs_pkg::TABLE_DEPTH - 1), $urandom);
        end else begin
            lo = $urandom_range(stbs_pkg::TABLE_DEPTH - 1);
            hi = $urandom_range(1) ? lo + $urandom_range(16)
                                   : $urandom_range(stbs_pkg::TABLE_DEPTH - 1);
            if (hi > stbs_pkg::TABLE_DEPTH - 1)
                hi = stbs_pkg::TABLE_DEPTH - 1;
            search_range($urandom, lo, hi);
        end
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_stall, input int n);
        int stop;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        stop      = beats_sent + n;
        while (beats_sent < stop) begin
            if ($urandom_range(9) < 7)
                run_segment();
            else
                run_noise();
        end
    endtask

    // Output side: check accepted beats, pick the stall for the next cycle
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall)
                sb.check_result(o_found, o_match_index);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Watchdog: too long without a beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        sb = new();
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_cmd           <= stbs_pkg::CMD_WRITE;
        i_element_index <= '0;
        i_element_value <= '0;
        i_search_key    <= '0;
        i_low_index     <= '0;
        i_high_index    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: sorted run with both value extremes, plus the top of the table
        write_entry(0, KEY_MIN);
        write_entry(1, -1000);
        write_entry(2, -1);
        write_entry(3, 0);
        write_entry(4, 1);
        write_entry(5, 5);
        write_entry(6, 1000);
        write_entry(7, KEY_MAX);
        write_entry(stbs_pkg::TABLE_DEPTH - 2, 32'sh7FFF_FFF0);
        write_entry(stbs_pkg::TABLE_DEPTH - 1, KEY_MAX);
        search_range(KEY_MIN, 0, 7);
        search_range(KEY_MAX, 0, 7);
        search_range(0, 0, 7);
        search_range(2, 0, 7);                                    // absent key
        search_range(-1000, 0, 0);                                // single entry, miss
        search_range(KEY_MIN, 0, 0);                              // single entry, hit
        search_range(5, 5, 4);                                    // empty range
        search_range(KEY_MAX, stbs_pkg::TABLE_DEPTH - 1, 0);      // empty range, top bits
        search_range(KEY_MAX, stbs_pkg::TABLE_DEPTH - 2, stbs_pkg::TABLE_DEPTH - 1);
        search_range(KEY_MAX, stbs_pkg::TABLE_DEPTH - 1, stbs_pkg::TABLE_DEPTH - 1);
        search_range(32'sh7FFF_FFF0, stbs_pkg::TABLE_DEPTH - 1, stbs_pkg::TABLE_DEPTH - 1);
        // Unsorted table: entry 4 now smaller than entries 1 to 3
        write_entry(4, -5000);
        search_range(-5000, 0, 7);
        search_range(5, 0, 7);

        // Random phases with different idling
        run_phase(0, 0, 80);
        run_phase(60, 0, 80);
        run_phase(0, 60, 80);
        run_phase(7, 7, 80);
        // Long output hold while input keeps coming
        hold_req++;
        run_phase(0, 0, 60);
        i_in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/stbs_pkg.sv
hdl/stbs_datapath.sv
hdl/stbs_ctrl.sv
hdl/sorted_table_binary_search.sv
sim/tb.sv
